// ----- src/best_fit_arena_allocator_macros.svh -----
// Assertion helpers shared by the allocator RTL.
`ifndef BEST_FIT_ARENA_ALLOCATOR_MACROS_SVH
`define BEST_FIT_ARENA_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define BFAA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bfaa: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while in reset.
`define BFAA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bfaa: next-cycle check failed");

`endif

// ----- src/bfaa_pkg.sv -----
`default_nettype none

package bfaa_pkg;

    localparam int FREE_SLOTS_DEF  = 64;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int REQ_BITS    = 24;
    localparam int SIZE_BITS   = 25;
    localparam int FIELD_BITS  = 32;
    localparam int COUNT_FIELD = 7;
    localparam int ACT_BITS    = 2;
    localparam int STAT_BITS   = 3;

    localparam logic [SIZE_BITS-1:0] GRAIN_ROUND = SIZE_BITS'(15);
    localparam logic [SIZE_BITS-1:0] GRAIN_MASK  = ~SIZE_BITS'(15);

    typedef enum logic [ACT_BITS-1:0] {
        ACT_RELEASE = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_CLEAR   = 2'd2
    } action_t;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_FROM_LIST = 3'd0,
        STAT_AT_TOP    = 3'd1,
        STAT_RELEASED  = 3'd2,
        STAT_DROPPED   = 3'd3,
        STAT_OVERFLOW  = 3'd4,
        STAT_CLEARED   = 3'd5
    } status_t;

    // Round a byte count up to the 16-byte grain.
    function automatic logic [SIZE_BITS-1:0] round16(input logic [REQ_BITS-1:0] bytes);
        logic [SIZE_BITS-1:0] sum;
        sum = SIZE_BITS'(bytes) + GRAIN_ROUND;
        return sum & GRAIN_MASK;
    endfunction

endpackage

`default_nettype wire

// ----- src/best_fit_arena_allocator.sv -----
`default_nettype none

// Channel   Dir  Word layout (low bit first)
// s_*       in   tuser: action[1:0]; tdata: request_size[23:0], release_offset[55:24]
// m_*       out  tuser: status[2:0]; tdata: granted_offset[31:0], arena_extent[63:32],
//                                            free_entries[70:64]
//
// Release, clear and unused actions go from accept straight to the result state.
// Allocate compares every free-list entry in turn (an empty list goes straight to the
// decision), using the single free-list read port feeding one size comparator;
// emptying a block adds the fetch and move states.
// Reset (aresetn low, synchronous) empties the free list and zeroes the arena top.
// A result waiting on m_tready does not block the next accept; it only stalls
// the following result.

module best_fit_arena_allocator
    import bfaa_pkg::*;
#(
    parameter int FREE_SLOTS  = FREE_SLOTS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // request_size[23:0], release_offset[55:24]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // granted_offset[31:0], arena_extent[63:32],
                                        // free_entries[70:64], zero fill above
    output logic [2:0]       m_tuser    // status[2:0]
);

    localparam int CNT_BITS  = $clog2(FREE_SLOTS + 1);
    localparam int IDX_BITS  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int EXT_BITS  = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;
    localparam int CEXT_BITS = (CNT_BITS > COUNT_FIELD) ? CNT_BITS : COUNT_FIELD;
    localparam int SUM_BITS  = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 1;
    localparam int ENTRY_BITS = OFFSET_BITS + SIZE_BITS;
    localparam logic [CNT_BITS-1:0] SLOTS_CNT = CNT_BITS'(FREE_SLOTS);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_FETCH  = 7'b0001000,
        S_MOVE   = 7'b0010000,
        S_RESULT = 7'b0100000,
        S_SPARE  = 7'b1000000
    } state_t;

    // Free list: {offset, size} per entry, one write and one read port.
    logic [ENTRY_BITS-1:0] free_mem [FREE_SLOTS];
    logic [ENTRY_BITS-1:0] rd_data_reg;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_wa;
    logic [ENTRY_BITS-1:0] mem_wd;
    logic                  mem_re;
    logic [IDX_BITS-1:0]   mem_ra;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    free_count_reg, free_count_next;
    logic [OFFSET_BITS-1:0] arena_top_reg, arena_top_next;
    logic [SIZE_BITS-1:0]   req_size_reg, req_size_next;
    logic [CNT_BITS-1:0]    issue_cnt_reg, issue_cnt_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [IDX_BITS-1:0]    rd_idx_reg, rd_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_BITS-1:0]    best_idx_reg, best_idx_next;
    logic [OFFSET_BITS-1:0] best_off_reg, best_off_next;
    logic [SIZE_BITS-1:0]   best_size_reg, best_size_next;
    logic [OFFSET_BITS-1:0] res_granted_reg, res_granted_next;
    status_t                res_status_reg, res_status_next;

    logic                   m_valid_reg, m_valid_next;
    logic [FIELD_BITS-1:0]  m_granted_reg, m_granted_next;
    logic [FIELD_BITS-1:0]  m_extent_reg, m_extent_next;
    logic [COUNT_FIELD-1:0] m_count_reg, m_count_next;
    status_t                m_status_reg, m_status_next;

    // Unpack the input word.
    logic [REQ_BITS-1:0]    in_req;
    logic [FIELD_BITS-1:0]  in_rel;
    logic [EXT_BITS-1:0]    rel_ext;
    logic [OFFSET_BITS-1:0] rel_off;
    logic [SIZE_BITS-1:0]   in_size;

    assign in_req  = s_tdata[REQ_BITS-1:0];
    assign in_rel  = s_tdata[REQ_BITS +: FIELD_BITS];
    assign rel_ext = EXT_BITS'(in_rel);
    assign rel_off = rel_ext[OFFSET_BITS-1:0];
    assign in_size = round16(in_req);

    // Fields of the entry coming back from the read port.
    logic [SIZE_BITS-1:0]   rd_size;
    logic [OFFSET_BITS-1:0] rd_off;

    assign rd_size = rd_data_reg[SIZE_BITS-1:0];
    assign rd_off  = rd_data_reg[ENTRY_BITS-1:SIZE_BITS];

    // Shared adder: carve a block front, or bump the arena top.
    logic [SUM_BITS-1:0]    add_a;
    logic [SUM_BITS-1:0]    add_sum;
    logic                   top_overflow;
    logic [SIZE_BITS-1:0]   carved_size;
    logic [CNT_BITS-1:0]    last_cnt;

    assign add_a        = found_reg ? SUM_BITS'(best_off_reg) : SUM_BITS'(arena_top_reg);
    assign add_sum      = add_a + SUM_BITS'(req_size_reg);
    assign top_overflow = |add_sum[SUM_BITS-1:OFFSET_BITS];
    assign carved_size  = best_size_reg - req_size_reg;
    assign last_cnt     = free_count_reg - 1'b1;

    // Output formatting to the fixed field widths.
    logic [EXT_BITS-1:0]  granted_ext;
    logic [EXT_BITS-1:0]  extent_ext;
    logic [CEXT_BITS-1:0] count_ext;

    assign granted_ext = EXT_BITS'(res_granted_reg);
    assign extent_ext  = EXT_BITS'(arena_top_reg);
    assign count_ext   = CEXT_BITS'(free_count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_extent_reg, m_granted_reg};

    always_comb begin
        state_next       = state_reg;
        free_count_next  = free_count_reg;
        arena_top_next   = arena_top_reg;
        req_size_next    = req_size_reg;
        issue_cnt_next   = issue_cnt_reg;
        rd_valid_next    = rd_valid_reg;
        rd_idx_next      = rd_idx_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_off_next    = best_off_reg;
        best_size_next   = best_size_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_granted_next   = m_granted_reg;
        m_extent_next    = m_extent_reg;
        m_count_next     = m_count_reg;
        m_status_next    = m_status_reg;
        mem_we           = 1'b0;
        mem_wa           = free_count_reg[IDX_BITS-1:0];
        mem_wd           = {rel_off, in_size};
        mem_re           = 1'b0;
        mem_ra           = issue_cnt_reg[IDX_BITS-1:0];

        // Drop the held result once the sink takes it.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_size_next    = in_size;
                    res_granted_next = '0;
                    state_next       = S_RESULT;
                    unique case (s_tuser)
                        ACT_RELEASE: begin
                            // Append at the list end unless the list is full.
                            if (free_count_reg < SLOTS_CNT) begin
                                mem_we          = 1'b1;
                                free_count_next = free_count_reg + 1'b1;
                                res_status_next = STAT_RELEASED;
                            end else begin
                                res_status_next = STAT_DROPPED;
                            end
                        end
                        ACT_ALLOC: begin
                            issue_cnt_next = '0;
                            rd_valid_next  = 1'b0;
                            found_next     = 1'b0;
                            state_next     = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            free_count_next = '0;
                            arena_top_next  = '0;
                            res_status_next = STAT_CLEARED;
                        end
                        default: begin
                            res_status_next = STAT_DROPPED;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue one read per cycle; compare the entry read last cycle.
                if (issue_cnt_reg < free_count_reg) begin
                    mem_re         = 1'b1;
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    rd_valid_next  = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IDX_BITS-1:0];
                end else begin
                    rd_valid_next = 1'b0;
                end
                // Strictly smaller keeps the lowest position on ties.
                if (rd_valid_reg && (rd_size >= req_size_reg)
                        && (!found_reg || (rd_size < best_size_reg))) begin
                    found_next     = 1'b1;
                    best_idx_next  = rd_idx_reg;
                    best_off_next  = rd_off;
                    best_size_next = rd_size;
                end
                if ((issue_cnt_reg == free_count_reg) && !rd_valid_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_RESULT;
                if (found_reg) begin
                    res_granted_next = best_off_reg;
                    res_status_next  = STAT_FROM_LIST;
                    if (carved_size == '0) begin
                        state_next = S_FETCH;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = best_idx_reg;
                        mem_wd = {add_sum[OFFSET_BITS-1:0], carved_size};
                    end
                end else if (top_overflow) begin
                    res_granted_next = '0;
                    res_status_next  = STAT_OVERFLOW;
                end else begin
                    res_granted_next = arena_top_reg;
                    arena_top_next   = add_sum[OFFSET_BITS-1:0];
                    res_status_next  = STAT_AT_TOP;
                end
            end
            S_FETCH: begin
                // Read the last entry to fill the emptied slot.
                mem_re     = 1'b1;
                mem_ra     = last_cnt[IDX_BITS-1:0];
                state_next = S_MOVE;
            end
            S_MOVE: begin
                mem_we          = 1'b1;
                mem_wa          = best_idx_reg;
                mem_wd          = rd_data_reg;
                free_count_next = last_cnt;
                state_next      = S_RESULT;
            end
            S_RESULT: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = granted_ext[FIELD_BITS-1:0];
                    m_extent_next  = extent_ext[FIELD_BITS-1:0];
                    m_count_next   = count_ext[COUNT_FIELD-1:0];
                    m_status_next  = res_status_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_count_reg <= '0;
            arena_top_reg  <= '0;
            issue_cnt_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            arena_top_reg  <= arena_top_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_valid_reg   <= rd_valid_next;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_size_reg    <= req_size_next;
        rd_idx_reg      <= rd_idx_next;
        best_idx_reg    <= best_idx_next;
        best_off_reg    <= best_off_next;
        best_size_reg   <= best_size_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        m_granted_reg   <= m_granted_next;
        m_extent_reg    <= m_extent_next;
        m_count_reg     <= m_count_next;
        m_status_reg    <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            free_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= free_mem[mem_ra];
        end
    end

    // Terms for the checks below.
    logic full_release;
    logic list_result;
    logic top_status;

    assign full_release = (state_reg == S_IDLE) && s_tvalid && (s_tuser == ACT_RELEASE)
                          && (free_count_reg == SLOTS_CNT);
    assign list_result  = (state_reg == S_RESULT) && (res_status_reg == STAT_FROM_LIST);
    assign top_status   = (res_status_reg == STAT_AT_TOP) || (res_status_reg == STAT_CLEARED);

`include "best_fit_arena_allocator_macros.svh"

    `BFAA_ASSERT_NOW(a_count_bound, 1'b1, free_count_reg <= SLOTS_CNT)
    `BFAA_ASSERT_NEXT(a_full_release_dropped, full_release, $stable(free_count_reg))
    `BFAA_ASSERT_NOW(a_list_grant_found, list_result, found_reg)
    `BFAA_ASSERT_NOW(a_top_moves_on_bump, !$stable(arena_top_reg), top_status)

endmodule

`default_nettype wire
